FILE: hw/rtl/source_lexer_assert.svh
// assertion macros used by the lexer top level
`ifndef SOURCE_LEXER_ASSERT_SVH
`define SOURCE_LEXER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SLX_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lexer check failed");

// next-cycle implication, checked out of reset
`define SLX_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lexer check failed");

`endif

FILE: hw/rtl/slx_pkg.sv
// types, constants and character class functions of the source lexer
package slx_pkg;

    localparam int OFFSET_BITS_DEF   = 16;
    localparam int KEYWORD_CHARS_DEF = 6;
    localparam int FIELD_BITS        = 16;
    localparam int MAX_RESULTS       = 3;

    localparam logic [5:0] K_IDENT       = 6'd0;
    localparam logic [5:0] K_NUM         = 6'd1;
    localparam logic [5:0] K_BOOL        = 6'd2;
    localparam logic [5:0] K_LET         = 6'd3;
    localparam logic [5:0] K_IF          = 6'd4;
    localparam logic [5:0] K_ELSE        = 6'd5;
    localparam logic [5:0] K_WHILE       = 6'd6;
    localparam logic [5:0] K_NULL        = 6'd7;
    localparam logic [5:0] K_VOID        = 6'd8;
    localparam logic [5:0] K_RET         = 6'd9;
    localparam logic [5:0] K_RETURN      = 6'd10;
    localparam logic [5:0] K_SINGLE_BASE = 6'd11;
    localparam logic [5:0] K_PAIR_BASE   = 6'd29;
    localparam logic [5:0] K_ERR         = 6'd42;
    localparam logic [5:0] K_NONE        = 6'd63;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUM,
        MODE_PEND,
        MODE_LINE,
        MODE_BLOCK,
        MODE_BSTAR,
        MODE_ERR
    } mode_t;

    typedef struct packed {
        logic [5:0]            kind;
        logic [FIELD_BITS-1:0] line;
        logic [FIELD_BITS-1:0] start;
        logic [FIELD_BITS-1:0] len;
        logic                  valid;
        logic                  last;
    } result_t;

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [5:0] single_kind(logic [7:0] c);
        logic [5:0] k;
        unique case (c)
            ";":     k = K_SINGLE_BASE + 6'd0;
            "(":     k = K_SINGLE_BASE + 6'd1;
            ")":     k = K_SINGLE_BASE + 6'd2;
            "=":     k = K_SINGLE_BASE + 6'd3;
            "+":     k = K_SINGLE_BASE + 6'd4;
            "*":     k = K_SINGLE_BASE + 6'd5;
            "-":     k = K_SINGLE_BASE + 6'd6;
            "/":     k = K_SINGLE_BASE + 6'd7;
            "{":     k = K_SINGLE_BASE + 6'd8;
            "}":     k = K_SINGLE_BASE + 6'd9;
            "<":     k = K_SINGLE_BASE + 6'd10;
            ">":     k = K_SINGLE_BASE + 6'd11;
            ",":     k = K_SINGLE_BASE + 6'd12;
            ".":     k = K_SINGLE_BASE + 6'd13;
            "!":     k = K_SINGLE_BASE + 6'd14;
            "%":     k = K_SINGLE_BASE + 6'd15;
            "[":     k = K_SINGLE_BASE + 6'd16;
            "]":     k = K_SINGLE_BASE + 6'd17;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] pair_kind(logic [7:0] a, logic [7:0] b);
        logic [5:0] k;
        unique case ({a, b})
            "==":    k = K_PAIR_BASE + 6'd0;
            "--":    k = K_PAIR_BASE + 6'd1;
            "++":    k = K_PAIR_BASE + 6'd2;
            "+=":    k = K_PAIR_BASE + 6'd3;
            "-=":    k = K_PAIR_BASE + 6'd4;
            "*=":    k = K_PAIR_BASE + 6'd5;
            "/=":    k = K_PAIR_BASE + 6'd6;
            "&&":    k = K_PAIR_BASE + 6'd7;
            "||":    k = K_PAIR_BASE + 6'd8;
            "!=":    k = K_PAIR_BASE + 6'd9;
            "<=":    k = K_PAIR_BASE + 6'd10;
            ">=":    k = K_PAIR_BASE + 6'd11;
            "%=":    k = K_PAIR_BASE + 6'd12;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    function automatic logic pair_start(logic [7:0] c);
        return c == "=" || c == "-" || c == "+" || c == "*" || c == "/" || c == "&"
            || c == "|" || c == "!" || c == "<" || c == ">" || c == "%";
    endfunction

    // window holds the identifier's first characters, right aligned
    function automatic logic [5:0] kw_kind(logic [63:0] win, logic [3:0] len);
        logic [5:0] k;
        k = K_IDENT;
        if (len == 4'd3 && win == 64'("let"))         k = K_LET;
        else if (len == 4'd2 && win == 64'("if"))     k = K_IF;
        else if (len == 4'd4 && win == 64'("else"))   k = K_ELSE;
        else if (len == 4'd5 && win == 64'("while"))  k = K_WHILE;
        else if (len == 4'd4 && win == 64'("null"))   k = K_NULL;
        else if (len == 4'd4 && win == 64'("void"))   k = K_VOID;
        else if (len == 4'd3 && win == 64'("ret"))    k = K_RET;
        else if (len == 4'd6 && win == 64'("return")) k = K_RETURN;
        else if (len == 4'd4 && win == 64'("true"))   k = K_BOOL;
        else if (len == 4'd5 && win == 64'("false"))  k = K_BOOL;
        return k;
    endfunction

endpackage

FILE: hw/rtl/slx_text_if.sv
// source byte channel of the lexer
interface slx_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

FILE: hw/rtl/slx_token_if.sv
// token channel of the lexer
interface slx_token_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [15:0] line_number;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic        token_valid;
    logic        last_of_run;

    modport source (output valid, output token_kind, output line_number,
                    output start_offset, output token_length, output token_valid,
                    output last_of_run, input ready);
    modport sink (input valid, input token_kind, input line_number,
                  input start_offset, input token_length, input token_valid,
                  input last_of_run, output ready);
endinterface

FILE: hw/rtl/slx_scan.sv
// next-state and token logic for one source byte
module slx_scan #(
    parameter int OFFSET_BITS   = slx_pkg::OFFSET_BITS_DEF,
    parameter int KEYWORD_CHARS = slx_pkg::KEYWORD_CHARS_DEF
) (
    input  slx_pkg::mode_t             mode,
    input  logic [7:0]                 held,
    input  logic [8*KEYWORD_CHARS-1:0] win,
    input  logic [OFFSET_BITS-1:0]     start,
    input  logic [OFFSET_BITS-1:0]     len,
    input  logic                       dec,
    input  logic [OFFSET_BITS-1:0]     off,
    input  logic [15:0]                line,
    input  logic [7:0]                 char_code,
    input  logic                       end_of_text,
    output slx_pkg::mode_t             mode_next,
    output logic [7:0]                 held_next,
    output logic [8*KEYWORD_CHARS-1:0] win_next,
    output logic [OFFSET_BITS-1:0]     start_next,
    output logic [OFFSET_BITS-1:0]     len_next,
    output logic                       dec_next,
    output logic [OFFSET_BITS-1:0]     off_next,
    output logic [15:0]                line_next,
    output slx_pkg::result_t           res [slx_pkg::MAX_RESULTS],
    output logic [1:0]                 res_count
);

    localparam int WinBits = 8 * KEYWORD_CHARS;

    function automatic logic [15:0] clamp(logic [OFFSET_BITS-1:0] v);
        logic [OFFSET_BITS-1:0] hi;
        hi = v >> 16;
        return (hi != '0) ? 16'hFFFF : 16'(v);
    endfunction

    function automatic slx_pkg::result_t make_res(logic [5:0] kind, logic [15:0] ln,
                                                  logic [OFFSET_BITS-1:0] st,
                                                  logic [OFFSET_BITS-1:0] le,
                                                  logic vld);
        slx_pkg::result_t r;
        r.kind  = kind;
        r.line  = ln;
        r.start = clamp(st);
        r.len   = clamp(le);
        r.valid = vld;
        r.last  = 1'b0;
        return r;
    endfunction

    function automatic logic [5:0] ident_kind(logic [WinBits-1:0] w,
                                              logic [OFFSET_BITS-1:0] l);
        logic [5:0] k;
        k = slx_pkg::K_IDENT;
        if (l <= OFFSET_BITS'(KEYWORD_CHARS))
        begin
            k = slx_pkg::kw_kind(64'(w), 4'(l));
        end
        return k;
    endfunction

    function automatic logic [OFFSET_BITS-1:0] sat_inc(logic [OFFSET_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    slx_pkg::mode_t             m;
    logic [7:0]                 h;
    logic [WinBits-1:0]         w;
    logic [OFFSET_BITS-1:0]     st;
    logic [OFFSET_BITS-1:0]     ln;
    logic                       d;
    logic [OFFSET_BITS-1:0]     o;
    logic [15:0]                lc;
    logic [1:0]                 n;
    logic                       fr;
    logic [5:0]                 k;
    logic                       word_ch;
    slx_pkg::result_t           r [slx_pkg::MAX_RESULTS];

    always_comb
    begin
        m  = mode;
        h  = held;
        w  = win;
        st = start;
        ln = len;
        d  = dec;
        o  = off;
        lc = line;
        n  = 2'd0;
        fr = 1'b0;
        k  = slx_pkg::K_NONE;
        word_ch = slx_pkg::is_alpha(char_code) || slx_pkg::is_digit(char_code)
                  || char_code == slx_pkg::CH_UNDER;
        for (int i = 0; i < slx_pkg::MAX_RESULTS; i++)
        begin
            r[i] = '0;
        end

        unique case (mode)
            slx_pkg::MODE_IDLE:
            begin
                fr = 1'b1;
            end
            slx_pkg::MODE_LINE:
            begin
                if (char_code == slx_pkg::CH_LF)
                begin
                    m = slx_pkg::MODE_IDLE;
                end
            end
            slx_pkg::MODE_BLOCK:
            begin
                if (char_code == slx_pkg::CH_STAR)
                begin
                    m = slx_pkg::MODE_BSTAR;
                end
            end
            slx_pkg::MODE_BSTAR:
            begin
                if (char_code == slx_pkg::CH_SLASH)
                begin
                    m = slx_pkg::MODE_IDLE;
                end
                else if (char_code != slx_pkg::CH_STAR)
                begin
                    m = slx_pkg::MODE_BLOCK;
                end
            end
            slx_pkg::MODE_IDENT:
            begin
                if (word_ch)
                begin
                    if (ln < OFFSET_BITS'(KEYWORD_CHARS))
                    begin
                        w = {w[WinBits-9:0], char_code};
                    end
                    ln = sat_inc(ln);
                end
                else
                begin
                    r[n] = make_res(ident_kind(w, ln), lc, st, ln, 1'b1);
                    n = n + 2'd1;
                    fr = 1'b1;
                end
            end
            slx_pkg::MODE_NUM:
            begin
                if (slx_pkg::is_digit(char_code) || (!d && char_code == slx_pkg::CH_DOT))
                begin
                    if (char_code == slx_pkg::CH_DOT)
                    begin
                        d = 1'b1;
                    end
                    ln = sat_inc(ln);
                end
                else
                begin
                    r[n] = make_res(slx_pkg::K_NUM, lc, st, ln, 1'b1);
                    n = n + 2'd1;
                    fr = 1'b1;
                end
            end
            slx_pkg::MODE_PEND:
            begin
                k = slx_pkg::pair_kind(held, char_code);
                if (held == slx_pkg::CH_SLASH && char_code == slx_pkg::CH_SLASH)
                begin
                    m = slx_pkg::MODE_LINE;
                end
                else if (held == slx_pkg::CH_SLASH && char_code == slx_pkg::CH_STAR)
                begin
                    m = slx_pkg::MODE_BLOCK;
                end
                else if (held == slx_pkg::CH_MINUS && slx_pkg::is_digit(char_code))
                begin
                    m  = slx_pkg::MODE_NUM;
                    ln = OFFSET_BITS'(2);
                    d  = 1'b0;
                end
                else if (k != slx_pkg::K_NONE)
                begin
                    r[n] = make_res(k, lc, st, OFFSET_BITS'(2), 1'b1);
                    n = n + 2'd1;
                    m = slx_pkg::MODE_IDLE;
                end
                else if (slx_pkg::single_kind(held) != slx_pkg::K_NONE)
                begin
                    r[n] = make_res(slx_pkg::single_kind(held), lc, st, OFFSET_BITS'(1), 1'b1);
                    n = n + 2'd1;
                    fr = 1'b1;
                end
                else
                begin
                    r[n] = make_res(slx_pkg::K_ERR, lc, st, OFFSET_BITS'(1), 1'b1);
                    n = n + 2'd1;
                    m = slx_pkg::MODE_ERR;
                end
            end
            slx_pkg::MODE_ERR:
            begin
                m = slx_pkg::MODE_ERR;
            end
            default:
            begin
                m = mode;
            end
        endcase

        // start of a new token at this byte
        if (fr)
        begin
            m = slx_pkg::MODE_IDLE;
            if (slx_pkg::is_alpha(char_code) || char_code == slx_pkg::CH_UNDER)
            begin
                m  = slx_pkg::MODE_IDENT;
                st = o;
                ln = OFFSET_BITS'(1);
                w  = WinBits'(char_code);
            end
            else if (slx_pkg::is_digit(char_code))
            begin
                m  = slx_pkg::MODE_NUM;
                st = o;
                ln = OFFSET_BITS'(1);
                d  = 1'b0;
            end
            else if (slx_pkg::is_space(char_code))
            begin
                m = slx_pkg::MODE_IDLE;
            end
            else if (slx_pkg::pair_start(char_code))
            begin
                m  = slx_pkg::MODE_PEND;
                h  = char_code;
                st = o;
            end
            else if (slx_pkg::single_kind(char_code) != slx_pkg::K_NONE)
            begin
                r[n] = make_res(slx_pkg::single_kind(char_code), lc, o, OFFSET_BITS'(1), 1'b1);
                n = n + 2'd1;
            end
            else
            begin
                r[n] = make_res(slx_pkg::K_ERR, lc, o, OFFSET_BITS'(1), 1'b1);
                n = n + 2'd1;
                m = slx_pkg::MODE_ERR;
            end
        end

        if (char_code == slx_pkg::CH_LF && lc != 16'hFFFF)
        begin
            lc = lc + 16'd1;
        end
        o = sat_inc(o);

        // end of text: flush, end word, back to reset values
        if (end_of_text)
        begin
            if (m == slx_pkg::MODE_IDENT)
            begin
                r[n] = make_res(ident_kind(w, ln), lc, st, ln, 1'b1);
                n = n + 2'd1;
            end
            else if (m == slx_pkg::MODE_NUM)
            begin
                r[n] = make_res(slx_pkg::K_NUM, lc, st, ln, 1'b1);
                n = n + 2'd1;
            end
            else if (m == slx_pkg::MODE_PEND)
            begin
                k = slx_pkg::single_kind(h);
                r[n] = make_res((k != slx_pkg::K_NONE) ? k : slx_pkg::K_ERR, lc, st,
                                OFFSET_BITS'(1), 1'b1);
                n = n + 2'd1;
            end
            r[n] = make_res(slx_pkg::K_IDENT, lc, o, '0, 1'b0);
            n = n + 2'd1;
            m  = slx_pkg::MODE_IDLE;
            h  = '0;
            w  = '0;
            st = '0;
            ln = '0;
            d  = 1'b0;
            o  = '0;
            lc = 16'd1;
        end

        if (n != 2'd0)
        begin
            r[n - 2'd1].last = 1'b1;
        end
    end

    assign mode_next  = m;
    assign held_next  = h;
    assign win_next   = w;
    assign start_next = st;
    assign len_next   = ln;
    assign dec_next   = d;
    assign off_next   = o;
    assign line_next  = lc;
    assign res        = r;
    assign res_count  = n;

endmodule

FILE: hw/rtl/source_lexer.sv
// source lexer top level: scan state, result buffer and handshakes
// One byte is taken per cycle unless words wait. Each byte yields zero to
// three words (at most one token flushed, one started, and the end word on an
// end_of_text byte); they leave one per cycle, while the sink is ready, from a
// three-entry result register. A byte is taken as the last word leaves, so
// with a ready sink a text whose bytes give at most one word each streams at
// one byte per clock; a byte giving more holds the input until the rest leave.
// Token text is not sent; offsets and lengths let the host find it in its copy.
module source_lexer #(
    parameter int OFFSET_BITS   = slx_pkg::OFFSET_BITS_DEF,
    parameter int KEYWORD_CHARS = slx_pkg::KEYWORD_CHARS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    slx_text_if.sink     text,
    slx_token_if.source  tokens
);

    `include "source_lexer_assert.svh"

    slx_pkg::mode_t             mode_reg,  mode_next;
    logic [7:0]                 held_reg,  held_next;
    logic [8*KEYWORD_CHARS-1:0] win_reg,   win_next;
    logic [OFFSET_BITS-1:0]     start_reg, start_next;
    logic [OFFSET_BITS-1:0]     len_reg,   len_next;
    logic                       dec_reg,   dec_next;
    logic [OFFSET_BITS-1:0]     off_reg,   off_next;
    logic [15:0]                line_reg,  line_next;

    slx_pkg::result_t res_new [slx_pkg::MAX_RESULTS];
    logic [1:0]       res_count;
    slx_pkg::result_t res_reg [slx_pkg::MAX_RESULTS];
    logic [1:0]       rem_reg;
    logic [1:0]       ptr_reg;
    slx_pkg::result_t head;
    logic             take;
    logic             give;

    slx_scan #(
        .OFFSET_BITS   (OFFSET_BITS),
        .KEYWORD_CHARS (KEYWORD_CHARS)
    ) u_scan (
        .mode        (mode_reg),
        .held        (held_reg),
        .win         (win_reg),
        .start       (start_reg),
        .len         (len_reg),
        .dec         (dec_reg),
        .off         (off_reg),
        .line        (line_reg),
        .char_code   (text.char_code),
        .end_of_text (text.end_of_text),
        .mode_next   (mode_next),
        .held_next   (held_next),
        .win_next    (win_next),
        .start_next  (start_next),
        .len_next    (len_next),
        .dec_next    (dec_next),
        .off_next    (off_next),
        .line_next   (line_next),
        .res         (res_new),
        .res_count   (res_count)
    );

    assign text.ready = (rem_reg == 2'd0) || (rem_reg == 2'd1 && tokens.ready);
    assign take       = text.valid && text.ready;
    assign give       = tokens.valid && tokens.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= slx_pkg::MODE_IDLE;
            held_reg  <= '0;
            win_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            dec_reg   <= 1'b0;
            off_reg   <= '0;
            line_reg  <= 16'd1;
            rem_reg   <= 2'd0;
            ptr_reg   <= 2'd0;
        end
        else if (take)
        begin
            mode_reg  <= mode_next;
            held_reg  <= held_next;
            win_reg   <= win_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            dec_reg   <= dec_next;
            off_reg   <= off_next;
            line_reg  <= line_next;
            rem_reg   <= res_count;
            ptr_reg   <= 2'd0;
        end
        else if (give)
        begin
            rem_reg <= rem_reg - 2'd1;
            ptr_reg <= ptr_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_new;
        end
    end

    assign head                = res_reg[ptr_reg];
    assign tokens.valid        = rem_reg != 2'd0;
    assign tokens.token_kind   = head.kind;
    assign tokens.line_number  = head.line;
    assign tokens.start_offset = head.start;
    assign tokens.token_length = head.len;
    assign tokens.token_valid  = head.valid;
    assign tokens.last_of_run  = head.last;

    `SLX_ASSERT_NOW(a_last_is_final, tokens.valid && tokens.last_of_run, rem_reg == 2'd1)
    `SLX_ASSERT_NEXT(a_end_gives_word, take && text.end_of_text, rem_reg != 2'd0)
    `SLX_ASSERT_NEXT(a_end_clears_offset, take && text.end_of_text, off_reg == '0)

endmodule
